@@ rtl/admc3_pkg.sv @@
// Shared types, constants and the saturation helper for the three-axis admittance controller.
// No dependencies; used by admc3_ctrl, admc3_dpath and the top level.
package admc3_pkg;

   // Axis count and Q16.16 word layout
   localparam int AXIS_COUNT = 3;
   localparam int AXIS_IDX_W = 2;
   localparam int VALUE_W    = 32;
   localparam int GAIN_W     = 32;
   localparam int STEP_W     = 17;
   localparam int FRAC_W     = 16;

   // Shared multiplier: signed 33x33, product kept at 65 bits
   localparam int MUL_W   = VALUE_W + 1;
   localparam int PROD_W  = VALUE_W + GAIN_W + 1;
   localparam int SHIFT_W = PROD_W - FRAC_W;
   localparam int ACCUM_W = SHIFT_W + 2;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_INV_GAIN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMP_GAIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRING_GAIN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP   = 2'd3;

   localparam logic [GAIN_W-1:0] INV_GAIN_RESET    = 32'd131072;
   localparam logic [GAIN_W-1:0] DAMP_GAIN_RESET   = 32'd2621440;
   localparam logic [GAIN_W-1:0] SPRING_GAIN_RESET = 32'd655360;
   localparam logic [STEP_W-1:0] TIME_STEP_RESET   = 17'd524;

   // Datapath operations, one per sequencer step
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE = 4'd0;
   localparam logic [OP_W-1:0] OP_KD   = 4'd1;
   localparam logic [OP_W-1:0] OP_KE   = 4'd2;
   localparam logic [OP_W-1:0] OP_SUB  = 4'd3;
   localparam logic [OP_W-1:0] OP_INV  = 4'd4;
   localparam logic [OP_W-1:0] OP_ACC  = 4'd5;
   localparam logic [OP_W-1:0] OP_EPSA = 4'd6;
   localparam logic [OP_W-1:0] OP_VEL  = 4'd7;
   localparam logic [OP_W-1:0] OP_EPSV = 4'd8;
   localparam logic [OP_W-1:0] OP_POS  = 4'd9;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic signed [ACCUM_W-1:0] accum_type;

   // Controller to datapath command
   typedef struct packed {
      logic                  load;
      logic                  publish;
      logic [OP_W-1:0]       op;
      logic [AXIS_IDX_W-1:0] axis;
   } cmd_type;

   localparam accum_type SAT_HI = {{(ACCUM_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
   localparam accum_type SAT_LO = {{(ACCUM_W-VALUE_W+1){1'b1}}, {(VALUE_W-1){1'b0}}};

   // Clamp a wide signed value to the signed value range
   function automatic value_type sat_value(input accum_type v);
      value_type res;
      if (v > SAT_HI) begin
         res = {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (v < SAT_LO) begin
         res = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         res = v[VALUE_W-1:0];
      end
      return res;
   endfunction

endpackage

@@ rtl/admc3_ctrl.sv @@
// Sequencer for the admittance controller: steps each axis through nine datapath operations.
// Depends on admc3_pkg; drives admc3_dpath through admc3_pkg::cmd_type.
module admc3_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output admc3_pkg::cmd_type  cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_KD   = 4'd1;
   localparam logic [3:0] ST_KE   = 4'd2;
   localparam logic [3:0] ST_SUB  = 4'd3;
   localparam logic [3:0] ST_INV  = 4'd4;
   localparam logic [3:0] ST_ACC  = 4'd5;
   localparam logic [3:0] ST_EPSA = 4'd6;
   localparam logic [3:0] ST_VEL  = 4'd7;
   localparam logic [3:0] ST_EPSV = 4'd8;
   localparam logic [3:0] ST_POS  = 4'd9;
   localparam logic [3:0] ST_DONE = 4'd10;

   localparam logic [admc3_pkg::AXIS_IDX_W-1:0] AXIS_LAST =
      admc3_pkg::AXIS_IDX_W'(admc3_pkg::AXIS_COUNT - 1);

   logic [3:0]                        state_ff, state_in;
   logic [admc3_pkg::AXIS_IDX_W-1:0] axis_ff, axis_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // Next state and command decode
   always_comb begin
      state_in    = state_ff;
      axis_in     = axis_ff;
      cmd.load    = 1'b0;
      cmd.publish = 1'b0;
      cmd.op      = admc3_pkg::OP_NONE;
      cmd.axis    = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               axis_in  = '0;
               state_in = ST_KD;
            end
         end
         ST_KD: begin
            cmd.op   = admc3_pkg::OP_KD;
            state_in = ST_KE;
         end
         ST_KE: begin
            cmd.op   = admc3_pkg::OP_KE;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            cmd.op   = admc3_pkg::OP_SUB;
            state_in = ST_INV;
         end
         ST_INV: begin
            cmd.op   = admc3_pkg::OP_INV;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op   = admc3_pkg::OP_ACC;
            state_in = ST_EPSA;
         end
         ST_EPSA: begin
            cmd.op   = admc3_pkg::OP_EPSA;
            state_in = ST_VEL;
         end
         ST_VEL: begin
            cmd.op   = admc3_pkg::OP_VEL;
            state_in = ST_EPSV;
         end
         ST_EPSV: begin
            cmd.op   = admc3_pkg::OP_EPSV;
            state_in = ST_POS;
         end
         ST_POS: begin
            cmd.op = admc3_pkg::OP_POS;
            if (axis_ff == AXIS_LAST) begin
               state_in = ST_DONE;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_KD;
            end
         end
         ST_DONE: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output beat tracking
   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/admc3_dpath.sv @@
// Datapath for the admittance controller: gain registers, axis state, one shared multiplier,
// accumulator and output registers. Depends on admc3_pkg; commanded by admc3_ctrl.
module admc3_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  admc3_pkg::cmd_type                   cmd,
   input  logic                                 csr_write_en,
   input  logic [admc3_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [admc3_pkg::CSR_DATA_W-1:0]     csr_data,
   input  admc3_pkg::value_type                 desired_force [admc3_pkg::AXIS_COUNT],
   input  admc3_pkg::value_type                 measured_force [admc3_pkg::AXIS_COUNT],
   output admc3_pkg::value_type                 accel_out [admc3_pkg::AXIS_COUNT],
   output admc3_pkg::value_type                 vel_out [admc3_pkg::AXIS_COUNT],
   output admc3_pkg::value_type                 pos_out [admc3_pkg::AXIS_COUNT]
);

   localparam int AXES = admc3_pkg::AXIS_COUNT;
   localparam int VW   = admc3_pkg::VALUE_W;
   localparam int AW   = admc3_pkg::ACCUM_W;
   localparam int MW   = admc3_pkg::MUL_W;
   localparam int PW   = admc3_pkg::PROD_W;
   localparam int SW   = admc3_pkg::SHIFT_W;
   localparam int FW   = admc3_pkg::FRAC_W;
   localparam int GW   = admc3_pkg::GAIN_W;
   localparam int TW   = admc3_pkg::STEP_W;

   // Configuration and axis state
   logic [GW-1:0]        inv_gain_ff, damp_gain_ff, spring_gain_ff;
   logic [TW-1:0]        step_ff;
   admc3_pkg::value_type vel_ff [AXES];
   admc3_pkg::value_type pos_ff [AXES];

   // Working registers
   admc3_pkg::value_type fd_ff [AXES];
   admc3_pkg::value_type ft_ff [AXES];
   admc3_pkg::value_type accel_ff [AXES];
   admc3_pkg::value_type opnd_ff;
   logic signed [PW-1:0] prod_ff;
   admc3_pkg::accum_type accum_ff;
   admc3_pkg::value_type acc_out_ff [AXES];
   admc3_pkg::value_type vel_out_ff [AXES];
   admc3_pkg::value_type pos_out_ff [AXES];

   logic signed [MW-1:0]   mul_a, mul_b;
   logic signed [2*MW-1:0] prod_full;
   logic signed [PW-1:0]   prod_in;
   logic signed [SW-1:0]   prod_shift;
   admc3_pkg::accum_type   shift_ext, force_diff, accum_minus, vel_sum, pos_sum;
   admc3_pkg::value_type   vel_cur, pos_cur, fd_cur, ft_cur;

   assign vel_cur = vel_ff[cmd.axis];
   assign pos_cur = pos_ff[cmd.axis];
   assign fd_cur  = fd_ff[cmd.axis];
   assign ft_cur  = ft_ff[cmd.axis];

   // Shared multiplier operand select: signed value times unsigned gain
   always_comb begin
      case (cmd.op)
         admc3_pkg::OP_KD: begin
            mul_a = {vel_cur[VW-1], vel_cur};
            mul_b = {1'b0, damp_gain_ff};
         end
         admc3_pkg::OP_KE: begin
            mul_a = {pos_cur[VW-1], pos_cur};
            mul_b = {1'b0, spring_gain_ff};
         end
         admc3_pkg::OP_INV: begin
            mul_a = {opnd_ff[VW-1], opnd_ff};
            mul_b = {1'b0, inv_gain_ff};
         end
         admc3_pkg::OP_EPSA, admc3_pkg::OP_EPSV: begin
            mul_a = {opnd_ff[VW-1], opnd_ff};
            mul_b = {{(MW-TW){1'b0}}, step_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_full = mul_a * mul_b;
   assign prod_in   = prod_full[PW-1:0];

   // Q16.16 rescale of the held product is an arithmetic shift (floor)
   assign prod_shift = $signed(prod_ff[PW-1:FW]);
   assign shift_ext  = {{(AW-SW){prod_shift[SW-1]}}, prod_shift};

   assign force_diff  = {{(AW-VW){fd_cur[VW-1]}}, fd_cur} - {{(AW-VW){ft_cur[VW-1]}}, ft_cur};
   assign accum_minus = accum_ff - shift_ext;
   assign vel_sum     = {{(AW-VW){vel_cur[VW-1]}}, vel_cur} + shift_ext;
   assign pos_sum     = {{(AW-VW){pos_cur[VW-1]}}, pos_cur} + shift_ext;

   // Gains and integrator state
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_gain_ff    <= admc3_pkg::INV_GAIN_RESET;
         damp_gain_ff   <= admc3_pkg::DAMP_GAIN_RESET;
         spring_gain_ff <= admc3_pkg::SPRING_GAIN_RESET;
         step_ff        <= admc3_pkg::TIME_STEP_RESET;
         for (int i = 0; i < AXES; i++) begin
            vel_ff[i] <= '0;
            pos_ff[i] <= '0;
         end
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               admc3_pkg::CSR_INV_GAIN:    inv_gain_ff    <= csr_data[GW-1:0];
               admc3_pkg::CSR_DAMP_GAIN:   damp_gain_ff   <= csr_data[GW-1:0];
               admc3_pkg::CSR_SPRING_GAIN: spring_gain_ff <= csr_data[GW-1:0];
               admc3_pkg::CSR_TIME_STEP:   step_ff        <= csr_data[TW-1:0];
               default: ;
            endcase
         end
         if (cmd.op == admc3_pkg::OP_VEL) begin
            vel_ff[cmd.axis] <= admc3_pkg::sat_value(vel_sum);
         end
         if (cmd.op == admc3_pkg::OP_POS) begin
            pos_ff[cmd.axis] <= admc3_pkg::sat_value(pos_sum);
         end
      end
   end

   // Per-step working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < AXES; i++) begin
            fd_ff[i] <= desired_force[i];
            ft_ff[i] <= measured_force[i];
         end
      end
      case (cmd.op)
         admc3_pkg::OP_KD: begin
            prod_ff  <= prod_in;
            accum_ff <= force_diff;
         end
         admc3_pkg::OP_KE: begin
            prod_ff  <= prod_in;
            accum_ff <= accum_minus;
         end
         admc3_pkg::OP_SUB: begin
            opnd_ff <= admc3_pkg::sat_value(accum_minus);
         end
         admc3_pkg::OP_INV, admc3_pkg::OP_EPSA, admc3_pkg::OP_EPSV: begin
            prod_ff <= prod_in;
         end
         admc3_pkg::OP_ACC: begin
            opnd_ff            <= admc3_pkg::sat_value(shift_ext);
            accel_ff[cmd.axis] <= admc3_pkg::sat_value(shift_ext);
         end
         admc3_pkg::OP_VEL: begin
            opnd_ff <= admc3_pkg::sat_value(vel_sum);
         end
         default: ;
      endcase
      // result beat register
      if (cmd.publish) begin
         for (int i = 0; i < AXES; i++) begin
            acc_out_ff[i] <= accel_ff[i];
            vel_out_ff[i] <= vel_ff[i];
            pos_out_ff[i] <= pos_ff[i];
         end
      end
   end

   assign accel_out = acc_out_ff;
   assign vel_out   = vel_out_ff;
   assign pos_out   = pos_out_ff;

endmodule

@@ rtl/admittance_controller_3axis_top.sv @@
// Three-axis admittance controller, top level: sequencer plus shared-multiplier datapath.
// Each request runs 9 steps per axis through the one multiplier, then a hand-off that raises
// rsp_valid; a new request is taken only once the sequencer is back in idle.
// The hand-off waits while the previous response beat has not been taken.
// Synchronous active-high reset: gains to defaults, velocity and position to zero, no beats.
// Depends on admc3_pkg, admc3_ctrl and admc3_dpath.
module admittance_controller_3axis_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [admc3_pkg::VALUE_W-1:0]  req_desired_force_x,
   input  logic signed [admc3_pkg::VALUE_W-1:0]  req_desired_force_y,
   input  logic signed [admc3_pkg::VALUE_W-1:0]  req_desired_force_z,
   input  logic signed [admc3_pkg::VALUE_W-1:0]  req_measured_force_x,
   input  logic signed [admc3_pkg::VALUE_W-1:0]  req_measured_force_y,
   input  logic signed [admc3_pkg::VALUE_W-1:0]  req_measured_force_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [admc3_pkg::VALUE_W-1:0]  rsp_accel_x,
   output logic signed [admc3_pkg::VALUE_W-1:0]  rsp_accel_y,
   output logic signed [admc3_pkg::VALUE_W-1:0]  rsp_accel_z,
   output logic signed [admc3_pkg::VALUE_W-1:0]  rsp_vel_x,
   output logic signed [admc3_pkg::VALUE_W-1:0]  rsp_vel_y,
   output logic signed [admc3_pkg::VALUE_W-1:0]  rsp_vel_z,
   output logic signed [admc3_pkg::VALUE_W-1:0]  rsp_pos_x,
   output logic signed [admc3_pkg::VALUE_W-1:0]  rsp_pos_y,
   output logic signed [admc3_pkg::VALUE_W-1:0]  rsp_pos_z,
   input  logic                                  csr_write_en,
   input  logic [admc3_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [admc3_pkg::CSR_DATA_W-1:0]      csr_data
);

   admc3_pkg::cmd_type   cmd;
   admc3_pkg::value_type desired_force [admc3_pkg::AXIS_COUNT];
   admc3_pkg::value_type measured_force [admc3_pkg::AXIS_COUNT];
   admc3_pkg::value_type accel_out [admc3_pkg::AXIS_COUNT];
   admc3_pkg::value_type vel_out [admc3_pkg::AXIS_COUNT];
   admc3_pkg::value_type pos_out [admc3_pkg::AXIS_COUNT];

   // Gather per-axis request fields
   assign desired_force[0]  = req_desired_force_x;
   assign desired_force[1]  = req_desired_force_y;
   assign desired_force[2]  = req_desired_force_z;
   assign measured_force[0] = req_measured_force_x;
   assign measured_force[1] = req_measured_force_y;
   assign measured_force[2] = req_measured_force_z;

   admc3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   admc3_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .desired_force  (desired_force),
      .measured_force (measured_force),
      .accel_out      (accel_out),
      .vel_out        (vel_out),
      .pos_out        (pos_out)
   );

   // Spread the response beat onto its fields
   assign rsp_accel_x = accel_out[0];
   assign rsp_accel_y = accel_out[1];
   assign rsp_accel_z = accel_out[2];
   assign rsp_vel_x   = vel_out[0];
   assign rsp_vel_y   = vel_out[1];
   assign rsp_vel_z   = vel_out[2];
   assign rsp_pos_x   = pos_out[0];
   assign rsp_pos_y   = pos_out[1];
   assign rsp_pos_z   = pos_out[2];

`ifndef NO_ASSERTIONS
   // one request at a time: ready drops right after an accepted beat
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a request is in flight");

   // a response only appears out of the busy sequence, never straight from idle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised without a request being processed");

   // the first axis step follows every accepted request
   a_start_step: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> cmd.op == admc3_pkg::OP_KD && cmd.axis == '0)
      else $error("sequencer did not start on the first axis");
`endif

endmodule

@@ dv/testbench.sv @@
// Self-checking bench for the three-axis admittance controller: directed table, then random phases.
// Carries its own Q16.16 mass-spring-damper predictor; depends on admc3_pkg and the top level.
module testbench;

   typedef struct packed {
      admc3_pkg::value_type [0:2] fd;
      admc3_pkg::value_type [0:2] ft;
   } force_type;

   typedef struct packed {
      admc3_pkg::value_type [0:2] accel;
      admc3_pkg::value_type [0:2] vel;
      admc3_pkg::value_type [0:2] pos;
   } motion_type;

   typedef struct {
      bit          reprog;
      logic [31:0] inv;
      logic [31:0] damp;
      logic [31:0] spring;
      logic [31:0] eps;
      force_type   frc;
      bit          zero_out;
   } stim_row_type;

   typedef enum {GAINS_DEFAULT, GAINS_SERVO, GAINS_RANDOM, GAINS_MAX, GAINS_ZERO} gain_plan_type;
   typedef enum {PACE_FREE, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_type;

   localparam admc3_pkg::value_type MAXV = 32'sh7FFF_FFFF;
   localparam admc3_pkg::value_type MINV = 32'sh8000_0000;
   localparam admc3_pkg::value_type ZV   = 32'sh0000_0000;
   localparam logic [31:0] GMAX = 32'hFFFF_FFFF;
   localparam logic [31:0] EPS_RESET = 32'(admc3_pkg::TIME_STEP_RESET);
   localparam longint WIDE_LIMIT = 64'sh2000_0000_0000_0000;
   localparam longint VALUE_HI = 64'sd2147483647;
   localparam longint VALUE_LO = -64'sd2147483648;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 125;
   localparam int SETTLE_CYCLES = 40;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   admc3_pkg::value_type req_desired_force_x, req_desired_force_y, req_desired_force_z;
   admc3_pkg::value_type req_measured_force_x, req_measured_force_y, req_measured_force_z;
   logic rsp_valid;
   logic rsp_ready;
   admc3_pkg::value_type rsp_accel_x, rsp_accel_y, rsp_accel_z;
   admc3_pkg::value_type rsp_vel_x, rsp_vel_y, rsp_vel_z;
   admc3_pkg::value_type rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic csr_write_en;
   logic [admc3_pkg::CSR_IDX_W-1:0] csr_index;
   logic [admc3_pkg::CSR_DATA_W-1:0] csr_data;

   // predictor copy of gains and integrator state
   logic [31:0] gain_inv, gain_damp, gain_spring;
   logic [16:0] step_eps;
   longint vel_state[3];
   longint pos_state[3];

   motion_type expected_motion[$];
   int err_count;
   int items_sent;
   int results_checked;
   int settings_used;
   int idle_pct;
   int stall_pct;
   string axis_names[3] = '{"x", "y", "z"};

   gain_plan_type gain_plan[PHASES] = '{GAINS_SERVO, GAINS_RANDOM, GAINS_DEFAULT, GAINS_MAX,
                                        GAINS_SERVO, GAINS_ZERO, GAINS_RANDOM, GAINS_SERVO};

   // directed rows: reprog, inv, damp, spring, eps, {fd x y z, ft x y z}, expect all zero
   stim_row_type directed_rows[18] = '{
      // fresh out of reset, no drive
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, {ZV, ZV, ZV, ZV, ZV, ZV}, 1'b1},
      // desired equals measured, state still zero
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0,
        {32'sh1234_5678, 32'shEDCB_A988, MAXV, 32'sh1234_5678, 32'shEDCB_A988, MAXV}, 1'b1},
      // force error saturates high, then low
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, {MAXV, MAXV, MAXV, MINV, MINV, MINV}, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, {MINV, MINV, MINV, MAXV, MAXV, MAXV}, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, {MAXV, MINV, MAXV, ZV, ZV, ZV}, 1'b0},
      // one LSB either way, floor rounding
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0,
        {32'shFFFF_FFFF, ZV, 32'sh0000_0001, ZV, 32'sh0000_0001, 32'shFFFF_FFFF}, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, {MINV, ZV, MAXV, ZV, MAXV, MINV}, 1'b0},
      // zero inverse gain
      '{1'b1, 32'd0, admc3_pkg::DAMP_GAIN_RESET, admc3_pkg::SPRING_GAIN_RESET, EPS_RESET,
        {MAXV, MINV, 32'sh0001_0000, ZV, ZV, ZV}, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, {ZV, ZV, ZV, ZV, ZV, ZV}, 1'b0},
      // all gains at max, time step with every bit set (above 1.0)
      '{1'b1, GMAX, GMAX, GMAX, GMAX, {MAXV, MINV, 32'sh0000_0001, MINV, MAXV, ZV}, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, {MINV, MAXV, ZV, MAXV, MINV, 32'sh0000_0001}, 1'b0},
      // everything zero: integrators hold
      '{1'b1, 32'd0, 32'd0, 32'd0, 32'd0, {MAXV, MINV, MAXV, MINV, MAXV, MINV}, 1'b0},
      // unit gain, unit time step, no damping or spring: pure integration
      '{1'b1, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000,
        {32'sh0001_0000, 32'shFFFF_0000, 32'sh7FFF_0000, ZV, ZV, ZV}, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0,
        {32'sh0001_0000, 32'shFFFF_0000, 32'sh7FFF_0000, ZV, ZV, ZV}, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0,
        {32'sh0001_0000, 32'shFFFF_0000, 32'sh7FFF_0000, ZV, ZV, ZV}, 1'b0},
      // back to defaults with small forces
      '{1'b1, admc3_pkg::INV_GAIN_RESET, admc3_pkg::DAMP_GAIN_RESET,
        admc3_pkg::SPRING_GAIN_RESET, EPS_RESET,
        {32'sh0005_0000, 32'shFFFC_8000, 32'sh0000_0001,
         32'sh0001_0000, 32'sh0002_0000, 32'shFFFF_FFFF}, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0,
        {32'sh0005_0000, 32'shFFFC_8000, 32'sh0000_0001, ZV, ZV, ZV}, 1'b0},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, {ZV, ZV, ZV, ZV, ZV, ZV}, 1'b0}
   };

   admittance_controller_3axis_top DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_desired_force_x  (req_desired_force_x),
      .req_desired_force_y  (req_desired_force_y),
      .req_desired_force_z  (req_desired_force_z),
      .req_measured_force_x (req_measured_force_x),
      .req_measured_force_y (req_measured_force_y),
      .req_measured_force_z (req_measured_force_z),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_accel_x          (rsp_accel_x),
      .rsp_accel_y          (rsp_accel_y),
      .rsp_accel_z          (rsp_accel_z),
      .rsp_vel_x            (rsp_vel_x),
      .rsp_vel_y            (rsp_vel_y),
      .rsp_vel_z            (rsp_vel_z),
      .rsp_pos_x            (rsp_pos_x),
      .rsp_pos_y            (rsp_pos_y),
      .rsp_pos_z            (rsp_pos_z),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   // clock, period 10
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop
   initial begin
      #5000000;
      $display("testbench: errors");
      $finish;
   end

   // floor(v*g/2^16), clamped to +-2^61
   function automatic longint scale_q16(input longint v, input logic [31:0] g);
      logic signed [127:0] prod;
      prod = $signed({{64{v[63]}}, v}) * $signed({96'd0, g});
      prod = prod >>> admc3_pkg::FRAC_W;
      if (prod > WIDE_LIMIT) return WIDE_LIMIT;
      if (prod < -WIDE_LIMIT) return -WIDE_LIMIT;
      return longint'(prod[63:0]);
   endfunction

   function automatic longint clamp_value(input longint v);
      if (v > VALUE_HI) return VALUE_HI;
      if (v < VALUE_LO) return VALUE_LO;
      return v;
   endfunction

   // one semi-implicit Euler step per axis; advances the integrator copy
   function automatic motion_type predict_motion(input force_type f);
      motion_type r;
      longint fd, ft, m, acc, vel, pos;
      for (int a = 0; a < admc3_pkg::AXIS_COUNT; a++) begin
         fd = $signed(f.fd[a]);
         ft = $signed(f.ft[a]);
         vel = vel_state[a];
         pos = pos_state[a];
         m = (fd - ft) - scale_q16(vel, gain_damp) - scale_q16(pos, gain_spring);
         m = clamp_value(m);
         acc = clamp_value(scale_q16(m, gain_inv));
         vel = clamp_value(vel + scale_q16(acc, {15'd0, step_eps}));
         pos = clamp_value(pos + scale_q16(vel, {15'd0, step_eps}));
         vel_state[a] = vel;
         pos_state[a] = pos;
         r.accel[a] = acc[31:0];
         r.vel[a] = vel[31:0];
         r.pos[a] = pos[31:0];
      end
      return r;
   endfunction

   function automatic void compare_field(input string group, input int a,
                                         input admc3_pkg::value_type want,
                                         input admc3_pkg::value_type got);
      if (want !== got) begin
         $error("%s_%s expected %0d got %0d", group, axis_names[a], want, got);
         err_count++;
      end
   endfunction

   // mostly servo-scale forces, some full range, some rails
   function automatic admc3_pkg::value_type random_force();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         return admc3_pkg::value_type'($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
      end else if (pick <= 7) begin
         return admc3_pkg::value_type'($urandom);
      end else if (pick == 8) begin
         return MAXV;
      end
      return MINV;
   endfunction

   // present one request beat and hold it until taken
   task automatic send_request(input force_type f, input bit zero_out);
      int gap;
      motion_type predicted;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 40);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_desired_force_x <= f.fd[0];
      req_desired_force_y <= f.fd[1];
      req_desired_force_z <= f.fd[2];
      req_measured_force_x <= f.ft[0];
      req_measured_force_y <= f.ft[1];
      req_measured_force_z <= f.ft[2];
      do @(posedge clock); while (!req_ready);
      predicted = predict_motion(f);
      if (zero_out) predicted = '0;
      expected_motion.push_back(predicted);
      items_sent++;
   endtask

   // drain, then write all four gain registers back to back
   task automatic program_gains(input logic [31:0] inv, input logic [31:0] damp,
                                input logic [31:0] spring, input logic [31:0] eps);
      req_valid <= 1'b0;
      while (expected_motion.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= admc3_pkg::CSR_INV_GAIN;
      csr_data <= inv;
      @(posedge clock);
      csr_index <= admc3_pkg::CSR_DAMP_GAIN;
      csr_data <= damp;
      @(posedge clock);
      csr_index <= admc3_pkg::CSR_SPRING_GAIN;
      csr_data <= spring;
      @(posedge clock);
      csr_index <= admc3_pkg::CSR_TIME_STEP;
      csr_data <= eps;
      @(posedge clock);
      csr_write_en <= 1'b0;
      gain_inv = inv;
      gain_damp = damp;
      gain_spring = spring;
      step_eps = eps[16:0];
      settings_used++;
   endtask

   // receiver backpressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // response checker
   always @(posedge clock) begin
      motion_type got;
      motion_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_accel_x, rsp_accel_y, rsp_accel_z, rsp_vel_x, rsp_vel_y, rsp_vel_z,
                rsp_pos_x, rsp_pos_y, rsp_pos_z};
         if (expected_motion.size() == 0) begin
            $error("response beat with no request outstanding");
            err_count++;
         end else begin
            want = expected_motion.pop_front();
            for (int a = 0; a < admc3_pkg::AXIS_COUNT; a++) begin
               compare_field("accel", a, want.accel[a], got.accel[a]);
               compare_field("vel", a, want.vel[a], got.vel[a]);
               compare_field("pos", a, want.pos[a], got.pos[a]);
            end
            results_checked++;
         end
      end
   end

   // stimulus
   initial begin
      stim_row_type row;
      force_type frc;
      logic [31:0] g_inv, g_damp, g_spring, g_eps;
      reset = 1'b1;
      req_valid = 1'b0;
      req_desired_force_x = '0;
      req_desired_force_y = '0;
      req_desired_force_z = '0;
      req_measured_force_x = '0;
      req_measured_force_y = '0;
      req_measured_force_z = '0;
      rsp_ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = admc3_pkg::CSR_INV_GAIN;
      csr_data = '0;
      idle_pct = 0;
      stall_pct = 0;
      err_count = 0;
      items_sent = 0;
      results_checked = 0;
      settings_used = 1;
      gain_inv = admc3_pkg::INV_GAIN_RESET;
      gain_damp = admc3_pkg::DAMP_GAIN_RESET;
      gain_spring = admc3_pkg::SPRING_GAIN_RESET;
      step_eps = admc3_pkg::TIME_STEP_RESET;
      for (int a = 0; a < admc3_pkg::AXIS_COUNT; a++) begin
         vel_state[a] = 0;
         pos_state[a] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.reprog) program_gains(row.inv, row.damp, row.spring, row.eps);
         send_request(row.frc, row.zero_out);
      end

      // random phases, each with its own gain set and pacing
      for (int p = 0; p < PHASES; p++) begin
         case (pace_type'(p % 4))
            PACE_FREE: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            PACE_SENDER_IDLE: begin
               idle_pct = 62;
               stall_pct = 0;
            end
            PACE_RECEIVER_STALL: begin
               idle_pct = 0;
               stall_pct = 62;
            end
            default: begin
               idle_pct = 12;
               stall_pct = 12;
            end
         endcase
         case (gain_plan[p])
            GAINS_SERVO: begin
               g_inv = $urandom_range(0, 32'h0004_0000);
               g_damp = $urandom_range(0, 32'h0040_0000);
               g_spring = $urandom_range(0, 32'h0040_0000);
               g_eps = $urandom_range(0, 32'h0000_1000);
            end
            GAINS_RANDOM: begin
               g_inv = $urandom;
               g_damp = $urandom;
               g_spring = $urandom;
               g_eps = $urandom;
            end
            GAINS_MAX: begin
               g_inv = GMAX;
               g_damp = GMAX;
               g_spring = GMAX;
               g_eps = GMAX;
            end
            GAINS_ZERO: begin
               g_inv = '0;
               g_damp = '0;
               g_spring = '0;
               g_eps = '0;
            end
            default: begin
               g_inv = admc3_pkg::INV_GAIN_RESET;
               g_damp = admc3_pkg::DAMP_GAIN_RESET;
               g_spring = admc3_pkg::SPRING_GAIN_RESET;
               g_eps = EPS_RESET;
            end
         endcase
         program_gains(g_inv, g_damp, g_spring, g_eps);
         repeat (PHASE_ITEMS) begin
            for (int a = 0; a < admc3_pkg::AXIS_COUNT; a++) begin
               frc.fd[a] = random_force();
               frc.ft[a] = random_force();
            end
            send_request(frc, 1'b0);
         end
      end

      // wind down
      req_valid <= 1'b0;
      while (expected_motion.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d request beats and %0d checked response beats", items_sent,
               results_checked);
      $display("across %0d gain settings and four sender/receiver pacing modes", settings_used);
      if (err_count == 0 && expected_motion.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/admc3_pkg.sv
rtl/admc3_ctrl.sv
rtl/admc3_dpath.sv
rtl/admittance_controller_3axis_top.sv
dv/testbench.sv
